>>> hdl/ring_predecessor_lookup_assert.svh
// Assertion macros for the checker file.
`ifndef RING_PREDECESSOR_LOOKUP_ASSERT_SVH
`define RING_PREDECESSOR_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RPL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rpl_pkg.sv
package rpl_pkg;

  // Field widths
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned OUSR_W = STS_W + 1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_DUP   = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an input transfer
    ST_SRCH,   // binary search: issue read of midpoint
    ST_SCMP,   // binary search: compare midpoint entry
    ST_FETCH,  // final entry read returned
    ST_SHRD,   // insert shift: read lower neighbor
    ST_SHWR,   // insert shift: write it one slot up
    ST_DONE    // result waiting for output register
  } state_e;

endpackage

>>> hdl/ring_predecessor_lookup.sv
// Sorted ring-key table with predecessor lookup.
// Input channel s_axis: tuser carries the action (insert, lookup, clear),
// tdata the 64-bit key. Output channel m_axis: one transfer per input
// transfer, tdata the result key, tuser the status and the wrapped flag.
// Keys sit in one synchronous RAM (one read, one write port, registered
// read data); one item is worked on at a time.
// Sequence, n = stored keys, s search steps (at most ceil(log2(n+1))):
//   clear, empty lookup, unused code: straight to the result state.
//   lookup: s search steps (midpoint read, then compare), then a final read.
//   insert: the same search and final read, then a shift that opens slot
//   p, moving n - p entries one slot up, each by a read and a write.
// Input ready is high only while the sequencer is idle, so a new item is
// taken only once the last one has reached the output register; that
// register lets the next item be taken while an earlier result still waits.
// Reset empties the table (count to zero); RAM contents are not cleared
// and need no clearing pass. A stalled receiver holds the output register;
// a later result waits in the sequencer until that register frees up.
module ring_predecessor_lookup #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rpl_pkg::KEY_W-1:0]    s_axis_tdata,   // [63:0] key_value
  input  logic [rpl_pkg::ACT_W-1:0]    s_axis_tuser,   // [1:0] action
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rpl_pkg::KEY_W-1:0]    m_axis_tdata,   // [63:0] result_key
  output logic [rpl_pkg::OUSR_W-1:0]   m_axis_tuser    // [1:0] status, [2] wrapped
);
  import rpl_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_e             state_q, state_d;
  logic [ACT_W-1:0]   act_q, act_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      lo_q, lo_d;
  logic [CW-1:0]      hi_q, hi_d;
  logic [CW-1:0]      mid_q, mid_d;
  logic [CW-1:0]      j_q, j_d;
  logic [KEY_W-1:0]   rkey_q, rkey_d;
  logic [STS_W-1:0]   rsts_q, rsts_d;
  logic               rwrap_q, rwrap_d;

  logic               out_vld_q;
  logic [KEY_W-1:0]   out_key_q;
  logic [OUSR_W-1:0]  out_usr_q;
  logic               out_load;

  // RAM port controls
  logic               ram_re, ram_we;
  logic [AW-1:0]      ram_raddr, ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [KEY_W-1:0]   rd_q;
  logic [KEY_W-1:0]   mem_q [TABLE_DEPTH];

  logic [CW-1:0]      mid_calc, cnt_m1, lo_m1, j_m1;
  logic               go_right;

  assign mid_calc = lo_q + ((hi_q - lo_q) >> 1);
  assign cnt_m1   = cnt_q - CW'(1);
  assign lo_m1    = lo_q - CW'(1);
  assign j_m1     = j_q - CW'(1);
  // Lookup counts keys at or below the query, insert keys strictly below
  assign go_right = (rd_q < key_q) || ((act_q == ACT_LOOKUP) && (rd_q == key_q));

  assign s_axis_tready = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    j_d       = j_q;
    rkey_d    = rkey_q;
    rsts_d    = rsts_q;
    rwrap_d   = rwrap_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = key_q;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          act_d   = s_axis_tuser;
          key_d   = s_axis_tdata;
          lo_d    = '0;
          hi_d    = cnt_q;
          rkey_d  = '0;
          rsts_d  = STS_OK;
          rwrap_d = 1'b0;
          priority if (s_axis_tuser == ACT_INSERT) begin
            state_d = ST_SRCH;
          end else if (s_axis_tuser == ACT_LOOKUP) begin
            if (cnt_q == '0) begin
              rsts_d  = STS_EMPTY;
              state_d = ST_DONE;
            end else begin
              state_d = ST_SRCH;
            end
          end else if (s_axis_tuser == ACT_CLEAR) begin
            cnt_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SRCH: begin
        ram_re = 1'b1;
        if (lo_q < hi_q) begin
          ram_raddr = mid_calc[AW-1:0];
          mid_d     = mid_calc;
          state_d   = ST_SCMP;
        end else begin
          // search done: read the entry that decides the result
          if (act_q == ACT_INSERT) begin
            ram_raddr = (lo_q < cnt_q) ? lo_q[AW-1:0] : '0;
          end else if (lo_q == '0) begin
            ram_raddr = cnt_m1[AW-1:0];
            rwrap_d   = 1'b1;
          end else begin
            ram_raddr = lo_m1[AW-1:0];
          end
          state_d = ST_FETCH;
        end
      end
      ST_SCMP: begin
        if (go_right) begin
          lo_d = mid_q + CW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SRCH;
      end
      ST_FETCH: begin
        if (act_q == ACT_INSERT) begin
          priority if ((lo_q < cnt_q) && (rd_q == key_q)) begin
            rsts_d  = STS_DUP;
            state_d = ST_DONE;
          end else if (cnt_q == DEPTH_C) begin
            rsts_d  = STS_FULL;
            state_d = ST_DONE;
          end else begin
            j_d     = cnt_q;
            state_d = ST_SHRD;
          end
        end else begin
          rkey_d  = rd_q;
          state_d = ST_DONE;
        end
      end
      ST_SHRD: begin
        if (j_q == lo_q) begin
          // slot opened: drop the new key in
          ram_we    = 1'b1;
          ram_waddr = lo_q[AW-1:0];
          ram_wdata = key_q;
          cnt_d     = cnt_q + CW'(1);
          state_d   = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_m1[AW-1:0];
          state_d   = ST_SHWR;
        end
      end
      ST_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        ram_wdata = rd_q;
        j_d       = j_m1;
        state_d   = ST_SHRD;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      act_q   <= ACT_INSERT;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      j_q     <= '0;
      rwrap_q <= 1'b0;
      rsts_q  <= STS_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      act_q   <= act_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      j_q     <= j_d;
      rwrap_q <= rwrap_d;
      rsts_q  <= rsts_d;
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    rkey_q <= rkey_d;
  end

  // Key RAM
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      mem_q[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      rd_q <= mem_q[ram_raddr];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_key_q <= rkey_q;
      out_usr_q <= {rwrap_q, rsts_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_key_q;
  assign m_axis_tuser  = out_usr_q;

endmodule

>>> hdl/rpl_checker.sv
`include "ring_predecessor_lookup_assert.svh"

module rpl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [rpl_pkg::KEY_W-1:0]    s_axis_tdata,
  input logic [rpl_pkg::ACT_W-1:0]    s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [rpl_pkg::KEY_W-1:0]    m_axis_tdata,
  input logic [rpl_pkg::OUSR_W-1:0]   m_axis_tuser
);
  import rpl_pkg::*;

  // Held result while the receiver stalls
  `RPL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed under stall")

  // Any non-ok status carries a zero key and no wrap
  `RPL_ASSERT_NOW(a_err_zero, m_axis_tvalid && (m_axis_tuser[STS_W-1:0] != STS_OK), (m_axis_tdata == '0) && !m_axis_tuser[STS_W], "error result with key or wrap")

  // One item at a time: ready drops after each input transfer
  `RPL_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule

bind ring_predecessor_lookup rpl_checker u_rpl_checker (.*);

>>> dv/tb_ring_predecessor_lookup.sv
`timescale 1ns / 1ps

module tb_ring_predecessor_lookup;
  import rpl_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int          NUM_ITEMS   = 1100;
  // Action code with no function: table untouched, all-zero result
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_MID    = {1'b1, {(KEY_W-1){1'b0}}};

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
  } ring_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [STS_W-1:0] status;
    logic             wrapped;
  } ring_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [KEY_W-1:0]   s_axis_tdata  = '0;  // [63:0] key_value
  logic [ACT_W-1:0]   s_axis_tuser  = '0;  // [1:0] action
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [KEY_W-1:0]   m_axis_tdata;        // [63:0] result_key
  logic [OUSR_W-1:0]  m_axis_tuser;        // [1:0] status, [2] wrapped

  ring_item_t         pending_items[$];
  ring_result_t       ring_results_due[$];
  logic [KEY_W-1:0]   ring_keys[$];        // predicted table, ascending
  logic [KEY_W-1:0]   inserted_keys[$];    // keys sent since last clear, for query picks
  int                 items_built = 0;
  int                 fail_cnt    = 0;
  int                 burst_left  = 0;
  int                 gap_left    = 0;
  int unsigned        rx_cycle    = 0;

  ring_predecessor_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Table update and result for one accepted transfer
  function automatic ring_result_t ring_table_step(input logic [ACT_W-1:0] act,
                                                   input logic [KEY_W-1:0] key);
    ring_result_t res;
    int           pos;
    res = '0;
    pos = 0;
    case (act)
      ACT_INSERT: begin
        while (pos < ring_keys.size() && ring_keys[pos] < key) pos++;
        if (pos < ring_keys.size() && ring_keys[pos] == key) begin
          res.status = STS_DUP;
        end else if (ring_keys.size() >= TABLE_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          ring_keys.insert(pos, key);
        end
      end
      ACT_LOOKUP: begin
        if (ring_keys.size() == 0) begin
          res.status = STS_EMPTY;
        end else begin
          while (pos < ring_keys.size() && ring_keys[pos] <= key) pos++;
          // nothing at or below the query: wrap to the largest key
          if (pos == 0) begin
            res.key     = ring_keys[ring_keys.size()-1];
            res.wrapped = 1'b1;
          end else begin
            res.key = ring_keys[pos-1];
          end
        end
      end
      ACT_CLEAR: ring_keys.delete();
      default: ;
    endcase
    return res;
  endfunction

  // Stimulus helpers
  function automatic void push_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key);
    ring_item_t it;
    it.act = act;
    it.key = key;
    pending_items.push_back(it);
    if (act != ACT_UNUSED) items_built++;
    if (act == ACT_CLEAR) inserted_keys.delete();
    if (act == ACT_INSERT) inserted_keys.push_back(key);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: k = KEY_W'($urandom_range(0, 200));
      1: k = ~KEY_W'($urandom_range(0, 200));
      2: k = KEY_W'($urandom) << $urandom_range(0, 32);
      default: ;
    endcase
    return k;
  endfunction

  // Query near a key already sent, at the ring ends, or a random key
  function automatic logic [KEY_W-1:0] query_key();
    logic [KEY_W-1:0] k;
    if (inserted_keys.size() == 0) return rand_key();
    k = inserted_keys[$urandom_range(0, inserted_keys.size()-1)];
    case ($urandom_range(0, 6))
      0, 1: ;
      2: k = k - 1'b1;
      3: k = k + 1'b1;
      4: k = '0;
      5: k = KEY_MAX;
      default: k = rand_key();
    endcase
    return k;
  endfunction

  // Inserts with lookups and repeated keys mixed in
  task automatic build_session(input int n_keys, input bit start_clear);
    int i;
    if (start_clear) push_item(ACT_CLEAR, rand_key());
    for (i = 0; i < n_keys; i++) begin
      push_item(ACT_INSERT, rand_key());
      repeat ($urandom_range(0, 2)) push_item(ACT_LOOKUP, query_key());
      if ($urandom_range(0, 7) == 0) begin
        push_item(ACT_INSERT, inserted_keys[$urandom_range(0, inserted_keys.size()-1)]);
      end
    end
    repeat ($urandom_range(1, 4)) push_item(ACT_LOOKUP, query_key());
  endtask

  // Fill the table past capacity; descending order makes every insert shift all
  task automatic build_full_table(input bit descending);
    int               i;
    logic [KEY_W-1:0] k;
    push_item(ACT_CLEAR, rand_key());
    for (i = 0; i < TABLE_DEPTH + 4; i++) begin
      k = descending ? (64'hF000_0000_0000_0000 - KEY_W'(i) * 64'h0123_4567_89AB)
                     : {$urandom, $urandom};
      push_item(ACT_INSERT, k);
    end
    // repeated key on a full table reports duplicate, not full
    push_item(ACT_INSERT, inserted_keys[$urandom_range(0, TABLE_DEPTH-1)]);
    repeat (8) push_item(ACT_LOOKUP, query_key());
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 6)) push_item(2'($urandom_range(0, 3)), rand_key());
  endtask

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk_i) begin : sender
    ring_item_t nxt;
    logic       stalled;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        ring_results_due.push_back(ring_table_step(s_axis_tuser, s_axis_tdata));
      end
      stalled = s_axis_tvalid && !s_axis_tready;
      if (!stalled) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.key;
          s_axis_tuser  <= nxt.act;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, drive ready on a rotating pattern
  always @(posedge clk_i) begin : receiver
    ring_result_t want;
    logic         rdy;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (ring_results_due.size() == 0) begin
          $error("result transfer with none outstanding: key %h user %b",
                 m_axis_tdata, m_axis_tuser);
          fail_cnt++;
        end else begin
          want = ring_results_due.pop_front();
          if (m_axis_tdata !== want.key) begin
            $error("result_key mismatch: expected %h, got %h", want.key, m_axis_tdata);
            fail_cnt++;
          end
          if (m_axis_tuser[STS_W-1:0] !== want.status) begin
            $error("status mismatch: expected %0d, got %0d",
                   want.status, m_axis_tuser[STS_W-1:0]);
            fail_cnt++;
          end
          if (m_axis_tuser[STS_W] !== want.wrapped) begin
            $error("wrapped mismatch: expected %0d, got %0d", want.wrapped, m_axis_tuser[STS_W]);
            fail_cnt++;
          end
        end
      end
      rx_cycle++;
      case (rx_cycle[10:9])
        2'd0:    rdy = 1'b1;
        2'd1:    rdy = ($urandom_range(0, 3) != 0);
        2'd2:    rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_cycle[5:0] < 6'd20);
      endcase
      m_axis_tready <= rdy;
    end
  end

  // Stimulus, reset and end of run
  initial begin : main
    int seq_no;

    // directed: empty table, ring ends, key zero, duplicates, unused code
    push_item(ACT_LOOKUP, '0);
    push_item(ACT_LOOKUP, KEY_MAX);
    push_item(ACT_UNUSED, KEY_MAX);
    push_item(ACT_INSERT, KEY_MID);
    push_item(ACT_INSERT, KEY_MID);
    push_item(ACT_LOOKUP, KEY_MID);
    push_item(ACT_LOOKUP, KEY_MID - 1'b1);
    push_item(ACT_INSERT, KEY_MAX);
    push_item(ACT_LOOKUP, KEY_MAX);
    push_item(ACT_LOOKUP, KEY_MAX - 1'b1);
    push_item(ACT_INSERT, '0);
    push_item(ACT_LOOKUP, '0);
    push_item(ACT_LOOKUP, 64'd5);
    push_item(ACT_INSERT, 64'd5);
    push_item(ACT_LOOKUP, 64'd4);
    push_item(ACT_LOOKUP, 64'd6);
    push_item(ACT_INSERT, '0);
    push_item(ACT_CLEAR, 64'h0123_4567_89AB_CDEF);
    push_item(ACT_LOOKUP, 64'h123);
    push_item(ACT_INSERT, 64'h123);
    push_item(ACT_LOOKUP, 64'h122);
    push_item(ACT_LOOKUP, KEY_MAX);
    push_item(ACT_UNUSED, '0);
    push_item(ACT_CLEAR, KEY_MAX);

    // random: mostly insert/lookup sessions, two full-table fills, some noise
    seq_no = 0;
    while (items_built < NUM_ITEMS) begin
      if (seq_no == 4) begin
        build_full_table(1'b0);
      end else if (seq_no == 20) begin
        build_full_table(1'b1);
      end else if ($urandom_range(0, 9) == 0) begin
        build_noise();
      end else begin
        build_session($urandom_range(1, 24), $urandom_range(0, 4) != 0);
      end
      seq_no++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || s_axis_tvalid || ring_results_due.size() > 0) begin
      @(negedge clk_i);
    end
    // longest insert latency on a nearly full table, plus margin
    repeat (600) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #16_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
